### hdl/lsbe_pkg.sv
// ----------------------------------------------------------------------------
// lsbe_pkg
// Shared constants, operation codes and control types of the LED strip
// SPI bit encoder.
// ----------------------------------------------------------------------------
package lsbe_pkg;

  localparam int LED_COUNT   = 64;
  localparam int RESET_BYTES = 5;
  localparam int BITS_PER_LED = 24;

  localparam int LED_AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int BIT_W  = $clog2(BITS_PER_LED);
  localparam int RB_W   = $clog2(RESET_BYTES + 1);
  localparam int IDX_W  = 6;
  localparam int CLR_W  = 8;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_SHOW  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  localparam logic [7:0] CODE_ONE   = 8'hF8;
  localparam logic [7:0] CODE_ZERO  = 8'hC0;
  localparam logic [7:0] CODE_RESET = 8'h00;

  typedef struct packed {
    logic              wr_en;
    logic [LED_AW-1:0] wr_addr;
    logic              rd_en;
    logic [LED_AW-1:0] rd_addr;
    logic              clear_all;
    logic              emit;
    logic              emit_data;
    logic              frame_end;
    logic              fresh;
    logic [BIT_W-1:0]  bit_sel;
  } lsbe_cmd_t;

  typedef struct packed {
    logic out_free;
  } lsbe_stat_t;

endpackage

### hdl/lsbe_ram.sv
// ----------------------------------------------------------------------------
// lsbe_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lsbe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/lsbe_dp.sv
// ----------------------------------------------------------------------------
// lsbe_dp
// Datapath: frame buffer with per-LED valid bits, current LED word and the
// output word register.
// ----------------------------------------------------------------------------
module lsbe_dp (
  input  logic               clk,
  input  logic               rst,
  input  lsbe_pkg::lsbe_cmd_t cmd,
  output lsbe_pkg::lsbe_stat_t stat,
  input  logic [7:0]         red,
  input  logic [7:0]         green,
  input  logic [7:0]         blue,
  output logic [7:0]         m_tdata,
  output logic               m_tlast,
  output logic               m_tvalid,
  input  logic               m_tready
);
  import lsbe_pkg::*;

  logic [LED_COUNT-1:0]    valid;
  logic                    rd_valid;
  logic [BITS_PER_LED-1:0] rd_data;
  logic [BITS_PER_LED-1:0] word;
  logic [BITS_PER_LED-1:0] word_sel;
  logic [BIT_W-1:0]        shift;
  logic                    code_bit;

  // stored in wire order: green, red, blue
  lsbe_ram #(.WIDTH(BITS_PER_LED), .DEPTH(LED_COUNT)) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (cmd.wr_addr),
    .wr_data ({green, red, blue}),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.clear_all) begin
        valid <= '0;
      end else if (cmd.wr_en) begin
        valid[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_valid <= valid[cmd.rd_addr] & ~cmd.clear_all;
      end
    end
  end

  assign word_sel = cmd.fresh ? (rd_valid ? rd_data : '0) : word;
  assign shift    = BIT_W'(BITS_PER_LED - 1) - cmd.bit_sel;
  assign code_bit = word_sel[shift];

  always_ff @(posedge clk) begin
    if (cmd.emit && cmd.emit_data && cmd.fresh) begin
      word <= word_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= cmd.emit_data ? (code_bit ? CODE_ONE : CODE_ZERO) : CODE_RESET;
      m_tlast <= cmd.frame_end;
    end
  end

  assign stat.out_free = ~m_tvalid | m_tready;

endmodule

### hdl/lsbe_ctrl.sv
// ----------------------------------------------------------------------------
// lsbe_ctrl
// Controller: decodes input words, walks LEDs and bits of a frame and the
// trailing reset bytes.
// ----------------------------------------------------------------------------
module lsbe_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [1:0]           op,
  input  logic [5:0]           led_index,
  input  lsbe_pkg::lsbe_stat_t stat,
  output lsbe_pkg::lsbe_cmd_t  cmd
);
  import lsbe_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEND = 2'd1;
  localparam logic [1:0] ST_TAIL = 2'd2;

  logic [1:0]        state, state_next;
  logic [LED_AW-1:0] led, led_next;
  logic [BIT_W-1:0]  bitpos, bitpos_next;
  logic [RB_W-1:0]   rbcnt, rbcnt_next;
  logic              acc;
  logic              tick;

  assign s_tready = stat.out_free;
  assign acc      = s_tvalid & s_tready;
  assign tick     = acc & (op == OP_TICK);

  always_comb begin
    state_next  = state;
    led_next    = led;
    bitpos_next = bitpos;
    rbcnt_next  = rbcnt;
    cmd         = '0;
    cmd.wr_addr = led_index[LED_AW-1:0];
    cmd.bit_sel = bitpos;
    cmd.fresh   = (bitpos == '0);
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          unique case (op) inside
            OP_SET: begin
              cmd.wr_en = ({1'b0, led_index} < 7'(LED_COUNT));
            end
            OP_SHOW, OP_CLEAR: begin
              cmd.rd_en     = 1'b1;
              cmd.rd_addr   = '0;
              cmd.clear_all = (op == OP_CLEAR);
              led_next      = '0;
              bitpos_next   = '0;
              rbcnt_next    = '0;
              state_next    = ST_SEND;
            end
            default: ;
          endcase
        end
      end
      ST_SEND: begin
        if (tick) begin
          cmd.emit      = 1'b1;
          cmd.emit_data = 1'b1;
          if (bitpos == BIT_W'(BITS_PER_LED - 1)) begin
            bitpos_next = '0;
            if (led == LED_AW'(LED_COUNT - 1)) begin
              state_next = ST_TAIL;
            end else begin
              led_next    = led + 1'b1;
              cmd.rd_en   = 1'b1;
              cmd.rd_addr = led + 1'b1;
            end
          end else begin
            bitpos_next = bitpos + 1'b1;
          end
        end
      end
      ST_TAIL: begin
        if (tick) begin
          cmd.emit = 1'b1;
          if (rbcnt == RB_W'(RESET_BYTES - 1)) begin
            cmd.frame_end = 1'b1;
            rbcnt_next    = '0;
            led_next      = '0;
            state_next    = ST_IDLE;
          end else begin
            rbcnt_next = rbcnt + 1'b1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      led    <= '0;
      bitpos <= '0;
      rbcnt  <= '0;
    end else begin
      state  <= state_next;
      led    <= led_next;
      bitpos <= bitpos_next;
      rbcnt  <= rbcnt_next;
    end
  end

  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (state != ST_IDLE))
    else $error("emit while idle");

  a_end_tail: assert property (@(posedge clk) disable iff (rst)
    cmd.frame_end |-> (state == ST_TAIL) && (rbcnt == RB_W'(RESET_BYTES - 1)))
    else $error("frame end outside last reset byte");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_en || cmd.clear_all) |-> (state == ST_IDLE))
    else $error("buffer changed during frame");

  a_bitpos_range: assert property (@(posedge clk) disable iff (rst)
    bitpos <= BIT_W'(BITS_PER_LED - 1))
    else $error("bit position out of range");

  a_tail_entry: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEND) && (state_next == ST_TAIL) |=> (rbcnt == '0) && (bitpos == '0))
    else $error("tail entered with stale counters");

endmodule

### hdl/led_strip_spi_bit_encoder_unit.sv
// ----------------------------------------------------------------------------
// led_strip_spi_bit_encoder_unit
// LED strip SPI bit encoder: 64-entry GRB frame buffer turned into one SPI
// code byte per tick, followed by reset bytes.
// ----------------------------------------------------------------------------
//  port group   dir  contents
//  s_*          in   command words: set LED, show, clear and show, tick
//  m_*          out  SPI code bytes, tlast on the last reset byte
//
//  One word per cycle: a tick that yields a byte is taken every cycle while
//  m_tready stays high; the frame buffer read of the next LED overlaps the
//  last bit of the current one.
//  s_tready drops only while the output register holds a byte not taken.
//  Reset (synchronous) clears all LEDs to zero and idles the frame sequencer.
// ----------------------------------------------------------------------------
module led_strip_spi_bit_encoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // led_index[5:0], red[13:6], green[21:14], blue[29:22]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // spi_byte[7:0]
  output logic        m_tlast    // frame_end
);
  import lsbe_pkg::*;

  lsbe_cmd_t  cmd;
  lsbe_stat_t stat;
  logic [1:0] pad_unused;

  assign pad_unused = s_tdata[31:30];

  lsbe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .op        (s_tuser),
    .led_index (s_tdata[5:0]),
    .stat      (stat),
    .cmd       (cmd)
  );

  lsbe_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .red      (s_tdata[13:6]),
    .green    (s_tdata[21:14]),
    .blue     (s_tdata[29:22]),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

endmodule

### tb/sv/lsbe_spi_checker.sv
// ----------------------------------------------------------------------------
// lsbe_spi_checker
// Watches the command and SPI byte streams of the LED strip encoder. Keeps its
// own frame buffer and frame sequencer, predicts the code byte of every tick
// and compares each byte taken from the block against the oldest prediction.
// ----------------------------------------------------------------------------
module lsbe_spi_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // led_index[5:0], red[13:6], green[21:14], blue[29:22]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // spi_byte[7:0]
  input  logic        m_tlast,   // frame_end
  output int          errors,
  output int          bytes_due,
  output int          bytes_seen,
  output int          frames_seen,
  output logic        frame_busy
);
  import lsbe_pkg::*;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } spi_byte_t;

  logic [23:0] led_rgb [LED_COUNT];   // red, green, blue from the top
  int unsigned led_pos;
  int unsigned bit_pos;
  int unsigned reset_cnt;
  spi_byte_t   code_queue [$];

  function automatic void start_frame();
    led_pos    = 0;
    bit_pos    = 0;
    reset_cnt  = 0;
    frame_busy = 1'b1;
  endfunction

  function automatic void encode_word(input logic [1:0] op, input logic [5:0] idx,
                                      input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    logic [23:0] grb;
    spi_byte_t   nxt;
    if (op != OP_TICK) begin
      if (frame_busy)
        return;
      if (op == OP_SET) begin
        if (idx < LED_COUNT)
          led_rgb[idx] = {r, g, b};
      end else if (op == OP_SHOW) begin
        start_frame();
      end else begin
        for (int i = 0; i < LED_COUNT; i++)
          led_rgb[i] = '0;
        start_frame();
      end
      return;
    end
    if (!frame_busy)
      return;
    if (led_pos < LED_COUNT) begin
      // wire order is green, red, blue, MSB first
      grb = {led_rgb[led_pos][15:8], led_rgb[led_pos][23:16], led_rgb[led_pos][7:0]};
      nxt.code = grb[BITS_PER_LED - 1 - bit_pos] ? CODE_ONE : CODE_ZERO;
      nxt.last = 1'b0;
      bit_pos++;
      if (bit_pos >= BITS_PER_LED) begin
        bit_pos = 0;
        led_pos++;
      end
    end else begin
      reset_cnt++;
      nxt.code = CODE_RESET;
      nxt.last = (reset_cnt >= RESET_BYTES);
      if (nxt.last) begin
        frame_busy = 1'b0;
        led_pos    = 0;
        bit_pos    = 0;
        reset_cnt  = 0;
      end
    end
    code_queue.push_back(nxt);
  endfunction

  always @(posedge clk) begin
    spi_byte_t want;
    if (rst) begin
      for (int i = 0; i < LED_COUNT; i++)
        led_rgb[i] = '0;
      led_pos     = 0;
      bit_pos     = 0;
      reset_cnt   = 0;
      frame_busy  = 1'b0;
      code_queue.delete();
      errors      = 0;
      bytes_due   = 0;
      bytes_seen  = 0;
      frames_seen = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        bytes_seen++;
        if (m_tlast)
          frames_seen++;
        if (code_queue.size() == 0) begin
          errors++;
          $error("unexpected SPI word: spi_byte %02h frame_end %0b", m_tdata, m_tlast);
        end else begin
          want = code_queue.pop_front();
          if (m_tdata !== want.code) begin
            errors++;
            $error("spi_byte: expected %02h, actual %02h", want.code, m_tdata);
          end
          if (m_tlast !== want.last) begin
            errors++;
            $error("frame_end: expected %0b, actual %0b", want.last, m_tlast);
          end
        end
      end
      if (s_tvalid && s_tready)
        encode_word(s_tuser, s_tdata[5:0], s_tdata[13:6], s_tdata[21:14], s_tdata[29:22]);
      bytes_due = code_queue.size();
    end
  end

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the LED strip SPI bit encoder: LED writes with
// extreme and random colors, then a frame run tick by tick with commands
// dropped while it runs. Sender gaps and receiver stalls follow a rotating
// schedule; a side checker predicts and compares every SPI word.
// ----------------------------------------------------------------------------
module tb;
  import lsbe_pkg::*;

  localparam int WORD_BUDGET = 1050;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int   errors;
  int   bytes_due;
  int   bytes_seen;
  int   frames_seen;
  logic frame_busy;

  int src_idle_pct  = 0;
  int dst_stall_pct = 0;
  int words_sent    = 0;

  led_strip_spi_bit_encoder_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  lsbe_spi_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .bytes_due   (bytes_due),
    .bytes_seen  (bytes_seen),
    .frames_seen (frames_seen),
    .frame_busy  (frame_busy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $error("timed out with %0d SPI words outstanding", bytes_due);
    $display("led_strip_spi_bit_encoder_unit: mismatch");
    $finish;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready = ($urandom_range(99) >= dst_stall_pct);
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [5:0] idx,
                           input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    // idle schedule rotates every 300 words
    case ((words_sent / 300) % 4)
      0: begin
        src_idle_pct  = 0;
        dst_stall_pct = 0;
      end
      1: begin
        src_idle_pct  = 81;
        dst_stall_pct = 0;
      end
      2: begin
        src_idle_pct  = 0;
        dst_stall_pct = 81;
      end
      default: begin
        src_idle_pct  = 30;
        dst_stall_pct = 30;
      end
    endcase
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = op;
    s_tdata  = {2'b00, b, g, r, idx};
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_rand(input logic [1:0] op);
    send_word(op, 6'($urandom_range(63)), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // ticks until the frame ends or the word budget is spent, with dropped
  // commands mixed in
  task automatic play_frame(input int noise_pct, input int budget);
    logic [1:0] op;
    while (frame_busy && (words_sent < budget)) begin
      op = OP_TICK;
      if ($urandom_range(99) < noise_pct)
        op = 2'($urandom_range(OP_CLEAR));
      send_rand(op);
    end
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_SET;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    send_word(OP_SET, 6'd0,  8'hFF, 8'hFF, 8'hFF);
    send_word(OP_SET, 6'd63, 8'hAA, 8'h55, 8'h0F);
    send_word(OP_SET, 6'd62, 8'h55, 8'hAA, 8'hF0);
    send_word(OP_SET, 6'd1,  8'h01, 8'h80, 8'h7F);
    send_word(OP_SET, 6'd32, 8'h80, 8'h01, 8'hFE);
    send_word(OP_SET, 6'd21, 8'h00, 8'hFF, 8'h00);
    send_rand(OP_TICK);   // idle ticks do nothing
    send_rand(OP_TICK);
    repeat (40) send_rand(($urandom_range(9) == 0) ? OP_TICK : OP_SET);
    send_rand(OP_SHOW);
    repeat (3) send_rand(OP_TICK);
    send_word(OP_SET, 6'd1, 8'hFF, 8'hFF, 8'hFF);   // dropped mid-frame
    send_rand(OP_SHOW);
    send_rand(OP_CLEAR);
    play_frame(6, WORD_BUDGET);
    s_tvalid = 1'b0;

    wait (bytes_due == 0);
    repeat (20) @(negedge clk);
    $display("sent %0d command words, checked %0d SPI words over %0d frames",
             words_sent, bytes_seen, frames_seen);
    if (errors == 0)
      $display("led_strip_spi_bit_encoder_unit: match");
    else
      $display("led_strip_spi_bit_encoder_unit: mismatch");
    $finish;
  end

endmodule

### files.f
hdl/lsbe_pkg.sv
hdl/lsbe_ram.sv
hdl/lsbe_dp.sv
hdl/lsbe_ctrl.sv
hdl/led_strip_spi_bit_encoder_unit.sv
tb/sv/lsbe_spi_checker.sv
tb/sv/tb.sv
